// File: rtl/core/hsi_cc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_cc_pkg
// Shared types, widths, codes and the hue ratio table of the HSI to RGB
// converter.
// ----------------------------------------------------------------------------
package hsi_cc_pkg;

    // field widths
    localparam int HUE_W   = 9;
    localparam int LVL_W   = 11;
    localparam int SEC_W   = 2;
    localparam int D_W     = 7;
    localparam int RATIO_W = 17;   // signed Q2.14
    localparam int FRAC_W  = 14;
    localparam int TERM_W  = 26;   // positive Q2.24 term, at most 3*2^24

    localparam int FULL_SCALE = 1024;
    localparam int FS_W   = $clog2(FULL_SCALE + 1);
    localparam int IFS_W  = LVL_W + FS_W;          // intensity * full scale
    localparam int PROD_W = IFS_W + TERM_W;
    localparam int QSH    = 34;                    // 2^24 term scale, 2^10 intensity
    localparam int SC_W   = PROD_W - QSH;          // level times three
    localparam int RCP_W  = 16;
    localparam int RCP_SH = 17;
    localparam logic [RCP_W-1:0] RECIP3 = RCP_W'(43691);  // ceil(2^17 / 3)

    localparam logic [HUE_W-1:0] HUE_WRAP   = HUE_W'(360);
    localparam logic [HUE_W-1:0] SECTOR_DEG = HUE_W'(120);
    localparam logic [HUE_W-1:0] SECTOR2_DEG = HUE_W'(240);
    localparam logic [LVL_W-1:0] UNIT_Q10   = LVL_W'(1024);
    localparam int ONE_Q24 = 1 << 24;
    localparam int ONE_Q14 = 1 << FRAC_W;

    // sector codes
    localparam logic [SEC_W-1:0] SEC_RED   = 2'd0;  // 0..119 deg, red leads
    localparam logic [SEC_W-1:0] SEC_GREEN = 2'd1;  // 120..239 deg, green leads
    localparam logic [SEC_W-1:0] SEC_BLUE  = 2'd2;  // 240..359 deg, blue leads

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [D_W-1:0]   offset;
        logic [LVL_W-1:0] sat;
        logic [LVL_W-1:0] inten;
    } t_item;

    typedef logic signed [RATIO_W-1:0] t_ratio_tab [0:119];

    localparam longint unsigned ONE_Q28   = 64'd268435456;
    localparam longint unsigned PI_Q28    = 64'd843314144;
    localparam longint unsigned SIXTY_Q28 = 64'd281104715;

    // unsigned shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 13-term Taylor cosine in Q4.28, each term truncated
    function automatic longint cos_q28(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 28;
        term = ONE_Q28;
        sum  = longint'(ONE_Q28);
        for (longint unsigned n = 1; n <= 12; n++) begin
            term = udiv64((term * x2) >> 28, (2 * n - 1) * (2 * n));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return sum;
    endfunction

    // cos(d)/cos(60 - d), rounded half away from zero to Q2.14
    function automatic t_ratio_tab build_ratio_tab();
        t_ratio_tab      tab;
        longint unsigned x;
        longint unsigned y;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint          c1;
        longint          c2;
        for (int d = 0; d < 120; d++) begin
            x   = (longint'(d) * PI_Q28) / 180;
            y   = (SIXTY_Q28 >= x) ? (SIXTY_Q28 - x) : (x - SIXTY_Q28);
            c1  = cos_q28(x);
            c2  = cos_q28(y);
            mag = (c1 < 0) ? longint'(-c1) : longint'(c1);
            den = (c2 > 0) ? longint'(c2) : 64'd1;
            q   = udiv64((mag << 15) + den, 2 * den);
            tab[d] = (c1 < 0) ? -RATIO_W'(q) : RATIO_W'(q);
        end
        return tab;
    endfunction

    localparam t_ratio_tab RATIO_TAB = build_ratio_tab();

endpackage

// File: rtl/core/hsi_cc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_cc_front
// Accepts one color, wraps the hue, finds its sector and offset and clamps
// saturation and intensity to 1.0.
// ----------------------------------------------------------------------------
module hsi_cc_front
    import hsi_cc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [HUE_W-1:0] i_hue_deg,
    input  logic [LVL_W-1:0] i_saturation,
    input  logic [LVL_W-1:0] i_intensity,
    output logic             o_valid,
    input  logic             i_ready,
    output t_item            o_item
);

    logic         r_valid;
    t_item        r_item;
    t_item        n_item;
    logic [HUE_W-1:0] hue_w;
    logic [HUE_W-1:0] off_w;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        hue_w = (i_hue_deg >= HUE_WRAP) ? (i_hue_deg - HUE_WRAP) : i_hue_deg;
        if (hue_w >= SECTOR2_DEG) begin
            n_item.sector = SEC_BLUE;
            off_w         = hue_w - SECTOR2_DEG;
        end else if (hue_w >= SECTOR_DEG) begin
            n_item.sector = SEC_GREEN;
            off_w         = hue_w - SECTOR_DEG;
        end else begin
            n_item.sector = SEC_RED;
            off_w         = hue_w;
        end
        n_item.offset = off_w[D_W-1:0];
        n_item.sat    = (i_saturation > UNIT_Q10) ? UNIT_Q10 : i_saturation;
        n_item.inten  = (i_intensity > UNIT_Q10) ? UNIT_Q10 : i_intensity;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// File: rtl/core/hsi_cc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_cc_queue
// Short register queue between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module hsi_cc_queue
    import hsi_cc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// File: rtl/core/hsi_cc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_cc_back
// Three-stage level pipeline: ratio lookup and terms, scaling by intensity,
// divide by three with clamp and channel routing into the output register.
// ----------------------------------------------------------------------------
module hsi_cc_back
    import hsi_cc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_item            i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [LVL_W-1:0] o_red,
    output logic [LVL_W-1:0] o_green,
    output logic [LVL_W-1:0] o_blue
);

    localparam int SUM_W = LVL_W + RATIO_W + 3;
    localparam logic signed [RATIO_W:0] CMP_ONE = (RATIO_W+1)'(ONE_Q14);
    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(ONE_Q24);

    // stage A: terms
    logic              r_a_valid;
    logic [SEC_W-1:0]  r_a_sector;
    logic [IFS_W-1:0]  r_a_ifs;
    logic [TERM_W-1:0] r_a_lead;
    logic [TERM_W-1:0] r_a_next;
    logic [TERM_W-1:0] r_a_trail;
    // stage B: three times the level
    logic              r_b_valid;
    logic [SEC_W-1:0]  r_b_sector;
    logic [SC_W-1:0]   r_b_lead;
    logic [SC_W-1:0]   r_b_next;
    logic [SC_W-1:0]   r_b_trail;
    // output register
    logic              r_o_valid;
    logic [LVL_W-1:0]  r_red;
    logic [LVL_W-1:0]  r_green;
    logic [LVL_W-1:0]  r_blue;

    logic adv_a;
    logic adv_b;
    logic adv_o;

    logic signed [RATIO_W-1:0]     ratio;
    logic signed [RATIO_W:0]       comp;
    logic signed [LVL_W:0]         sat_s;
    logic signed [SUM_W-1:0]       lead_sum;
    logic signed [SUM_W-1:0]       next_sum;
    logic [TERM_W-1:0]             n_a_lead;
    logic [TERM_W-1:0]             n_a_next;
    logic [TERM_W-1:0]             n_a_trail;
    logic [LVL_W-1:0]              sat_rest;
    logic [PROD_W-1:0]             p_lead;
    logic [PROD_W-1:0]             p_next;
    logic [PROD_W-1:0]             p_trail;
    logic [LVL_W-1:0]              v_lead;
    logic [LVL_W-1:0]              v_next;
    logic [LVL_W-1:0]              v_trail;

    // floor(s / 3), clamped to full scale, kept to the field width
    function automatic logic [LVL_W-1:0] third_clamp(input logic [SC_W-1:0] s);
        logic [SC_W+RCP_W-1:0] m;
        logic [SC_W+RCP_W-RCP_SH-1:0] q;
        m = SC_W'(s) * RECIP3;
        q = m[SC_W+RCP_W-1:RCP_SH];
        if (q > (SC_W+RCP_W-RCP_SH)'(FULL_SCALE))
            q = (SC_W+RCP_W-RCP_SH)'(FULL_SCALE);
        return q[LVL_W-1:0];
    endfunction

    assign adv_o   = !r_o_valid || i_ready;
    assign adv_b   = !r_b_valid || adv_o;
    assign adv_a   = !r_a_valid || adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_o_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    always_comb begin
        ratio    = RATIO_TAB[i_item.offset];
        comp     = CMP_ONE - (RATIO_W+1)'(ratio);
        sat_s    = $signed({1'b0, i_item.sat});
        lead_sum = SUM_ONE + SUM_W'(sat_s * ratio);
        next_sum = SUM_ONE + SUM_W'(sat_s * comp);
        n_a_lead = (lead_sum > 0) ? lead_sum[TERM_W-1:0] : '0;
        n_a_next = (next_sum > 0) ? next_sum[TERM_W-1:0] : '0;
        sat_rest = UNIT_Q10 - i_item.sat;
        n_a_trail = TERM_W'({sat_rest, {FRAC_W{1'b0}}});
    end

    assign p_lead  = PROD_W'(r_a_ifs) * PROD_W'(r_a_lead);
    assign p_next  = PROD_W'(r_a_ifs) * PROD_W'(r_a_next);
    assign p_trail = PROD_W'(r_a_ifs) * PROD_W'(r_a_trail);

    assign v_lead  = third_clamp(r_b_lead);
    assign v_next  = third_clamp(r_b_next);
    assign v_trail = third_clamp(r_b_trail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv_a) r_a_valid <= i_valid;
            if (adv_b) r_b_valid <= r_a_valid;
            if (adv_o) r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_a_sector <= i_item.sector;
            r_a_ifs    <= IFS_W'(i_item.inten) * IFS_W'(FULL_SCALE);
            r_a_lead   <= n_a_lead;
            r_a_next   <= n_a_next;
            r_a_trail  <= n_a_trail;
        end
        if (adv_b && r_a_valid) begin
            r_b_sector <= r_a_sector;
            r_b_lead   <= p_lead[PROD_W-1:QSH];
            r_b_next   <= p_next[PROD_W-1:QSH];
            r_b_trail  <= p_trail[PROD_W-1:QSH];
        end
        if (adv_o && r_b_valid) begin
            unique case (r_b_sector)
                SEC_RED: begin
                    r_red   <= v_lead;
                    r_green <= v_next;
                    r_blue  <= v_trail;
                end
                SEC_GREEN: begin
                    r_red   <= v_trail;
                    r_green <= v_lead;
                    r_blue  <= v_next;
                end
                default: begin
                    r_red   <= v_next;
                    r_green <= v_trail;
                    r_blue  <= v_lead;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/hsi_to_rgb_color_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsi_to_rgb_color_convert
// HSI to RGB duty level converter: one hue/saturation/intensity item in,
// one red/green/blue item out.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+------------------------------------
//  s (in)   | in  | i_s_tvalid/o_s_tready  | i_s_tdata: hue, saturation, intensity
//  m (out)  | out | o_m_tvalid/i_m_tready  | o_m_tdata: red, green, blue
//
//  One item per clock sustained while i_m_tready stays high. Five register
//  stages: front register (loaded at the accepting edge), queue, term stage,
//  scaling multiply stage, divide-by-three/clamp into the output register.
//  Reset is synchronous, active low; it empties the pipeline and the queue.
//  The front only stalls when the four-entry queue is full; the back stalls
//  stage by stage from i_m_tready, so the front keeps taking items meanwhile.
// ----------------------------------------------------------------------------
module hsi_to_rgb_color_convert
    import hsi_cc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [8:0] hue_deg, [19:9] saturation,
                                     // [30:20] intensity, [31] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [10:0] red, [21:11] green,
                                     // [32:22] blue, [39:33] zero
);

    // front to queue
    logic  fr_valid;
    logic  fr_ready;
    t_item fr_item;
    // queue to back
    logic  bk_valid;
    logic  bk_ready;
    t_item bk_item;

    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;

    // Sector and offset classify, input clamps.
    hsi_cc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_hue_deg    (i_s_tdata[HUE_W-1:0]),
        .i_saturation (i_s_tdata[HUE_W+LVL_W-1:HUE_W]),
        .i_intensity  (i_s_tdata[HUE_W+2*LVL_W-1:HUE_W+LVL_W]),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_item       (fr_item)
    );

    // Decouples the front from output backpressure.
    hsi_cc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_item  (fr_item),
        .o_pop_valid  (bk_valid),
        .i_pop_ready  (bk_ready),
        .o_pop_item   (bk_item)
    );

    // Level arithmetic and channel routing.
    hsi_cc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bk_valid),
        .o_ready (bk_ready),
        .i_item  (bk_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign o_m_tdata = {7'd0, blue, green, red};

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hsi_to_rgb_color_convert. A short directed table
// covers the extremes of hue, saturation and intensity, the sector edges and
// the hue wrap. Random colors follow, with random gaps on the input side and
// random back-pressure on the output side. Every output item is checked
// field by field against typed levels or a local model of the conversion.
// ----------------------------------------------------------------------------
module testbench;
    import hsi_cc_pkg::*;

    // run shape
    localparam int N_RAND       = 1430;
    localparam int MODE_SPAN    = 250;    // items per idling mode
    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 12;     // five-stage pipe plus margin
    localparam int MAX_REPORTS  = 10;

    // fixed-point constants of the ratio table (Q4.28)
    localparam longint unsigned ANG_ONE_Q28  = 64'd268435456;
    localparam longint unsigned ANG_PI_Q28   = 64'd843314144;
    localparam longint unsigned ANG_60_Q28   = 64'd281104715;
    localparam int              HUE_FULL_DEG = 360;
    localparam int              HUE_SEC_DEG  = 120;
    localparam int              UNIT_LVL     = 1024;

    // directed table columns
    localparam int COL_HUE   = 0;
    localparam int COL_SAT   = 1;
    localparam int COL_INT   = 2;
    localparam int COL_KNOWN = 3;   // 1: expected levels typed in the row
    localparam int COL_RED   = 4;
    localparam int COL_GREEN = 5;
    localparam int COL_BLUE  = 6;
    localparam int N_COLS    = 7;
    localparam int N_DIR     = 24;

    // hue, sat, inten, known, red, green, blue
    localparam int DIR_ROWS [N_DIR][N_COLS] = '{
        '{  0,    0,    0, 1,    0,    0,    0},  // all zero
        '{  0,    0, 1024, 1,  341,  341,  341},  // gray, full intensity
        '{200,    0, 2047, 1,  341,  341,  341},  // gray, intensity saturates
        '{  0, 1024, 1024, 1, 1024,    0,    0},  // pure red at full scale
        '{120, 1024, 1024, 1,    0, 1024,    0},  // green sector start
        '{240, 1024, 1024, 1,    0,    0, 1024},  // blue sector start
        '{360, 2047, 2047, 1, 1024,    0,    0},  // wrap to 0, both saturate
        '{480, 1024, 1500, 1,    0, 1024,    0},  // wrap to 120
        '{  1, 1024,    0, 1,    0,    0,    0},  // zero intensity
        '{511, 1024, 1024, 0,    0,    0,    0},  // largest hue, wraps to 151
        '{359, 1024, 1024, 0,    0,    0,    0},
        '{119, 1024, 1024, 0,    0,    0,    0},
        '{239,  512, 1024, 0,    0,    0,    0},
        '{ 60, 1024, 1024, 0,    0,    0,    0},
        '{180, 1025, 1025, 0,    0,    0,    0},  // just above unit
        '{300,  700, 2047, 0,    0,    0,    0},
        '{256,    1,    1, 0,    0,    0,    0},
        '{170, 2047, 1000, 0,    0,    0,    0},
        '{ 90,  341,  683, 0,    0,    0,    0},
        '{ 30, 1024,  512, 0,    0,    0,    0},
        '{400,  800, 1024, 0,    0,    0,    0},
        '{ 45, 1023, 1023, 0,    0,    0,    0},
        '{121,    2, 1024, 0,    0,    0,    0},
        '{241, 1024,    1, 0,    0,    0,    0}
    };

    localparam int HUE_EDGES [10] = '{0, 1, 119, 120, 121, 239, 240, 359, 360, 511};
    localparam int LVL_EDGES [6]  = '{0, 1, 1023, 1024, 1025, 2047};

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [LVL_W-1:0] sat;
        logic [LVL_W-1:0] inten;
    } t_hsi;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_rgb;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // ratio cos(d)/cos(60 - d) per degree of sector offset, Q2.14
    logic signed [RATIO_W-1:0] hue_ratio [0:HUE_SEC_DEG-1];

    t_rgb rgb_due_q [$];   // expected colors, oldest first
    int   fail_count  = 0;
    int   out_count   = 0;
    int   idle_cycles = 0;

    // current input item: typed expectation for directed rows
    bit   cur_known = 1'b0;
    t_rgb cur_rgb   = '0;

    // idling switches, changed per span of items
    bit   tx_gaps_on   = 1'b0;
    bit   rx_stalls_on = 1'b0;
    int   stall_left   = 0;

    hsi_to_rgb_color_convert dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------

    // 13-term Taylor cosine, Q4.28, every term truncated
    function automatic longint taylor_cosine(longint unsigned ang);
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned k;
        longint          acc;
        ang_sq = (ang * ang) >> 28;
        term   = ANG_ONE_Q28;
        acc    = longint'(ANG_ONE_Q28);
        for (k = 1; k <= 12; k++) begin
            term = ((term * ang_sq) >> 28) / ((2 * k - 1) * (2 * k));
            if (k[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    function automatic void fill_hue_ratio();
        longint unsigned ang;
        longint unsigned comp;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quo;
        longint          c_num;
        longint          c_den;
        for (int d = 0; d < HUE_SEC_DEG; d++) begin
            ang   = (longint'(d) * ANG_PI_Q28) / 180;
            comp  = (ANG_60_Q28 >= ang) ? (ANG_60_Q28 - ang) : (ang - ANG_60_Q28);
            c_num = taylor_cosine(ang);
            c_den = taylor_cosine(comp);
            mag   = (c_num < 0) ? longint'(-c_num) : longint'(c_num);
            den   = (c_den > 0) ? longint'(c_den) : 64'd1;
            // round half away from zero
            quo   = ((mag << 15) + den) / (2 * den);
            hue_ratio[d] = (c_num < 0) ? -RATIO_W'(quo) : RATIO_W'(quo);
        end
    endfunction

    // full_scale * I/3 * term/2^24, truncated, clamped, cut to the field
    function automatic logic [LVL_W-1:0] duty_level(longint inten, longint term);
        t_u64 v;
        if (term <= 0)
            return '0;
        v = (t_u64'(FULL_SCALE) * t_u64'(inten) * t_u64'(term)) / (64'd3 << 34);
        if (v > t_u64'(FULL_SCALE))
            v = t_u64'(FULL_SCALE);
        return LVL_W'(v);
    endfunction

    function automatic t_rgb hsi_to_rgb_predict(t_hsi item);
        int unsigned      h;
        logic [SEC_W-1:0] sector;
        longint           s;
        longint           i;
        longint           r;
        logic [LVL_W-1:0] lead;
        logic [LVL_W-1:0] follow;
        logic [LVL_W-1:0] trail;
        t_rgb             res;
        h      = int'(item.hue) % HUE_FULL_DEG;
        sector = SEC_W'(h / HUE_SEC_DEG);
        s      = (item.sat > UNIT_LVL) ? UNIT_LVL : longint'(item.sat);
        i      = (item.inten > UNIT_LVL) ? UNIT_LVL : longint'(item.inten);
        r      = hue_ratio[h % HUE_SEC_DEG];
        lead   = duty_level(i, (longint'(1) << 24) + s * r);
        follow = duty_level(i, (longint'(1) << 24) + s * (longint'(ONE_Q14) - r));
        trail  = duty_level(i, (UNIT_LVL - s) * ONE_Q14);
        case (sector)
            SEC_RED: begin
                res = '{red: lead, green: follow, blue: trail};
            end
            SEC_GREEN: begin
                res = '{red: trail, green: lead, blue: follow};
            end
            default: begin
                res = '{red: follow, green: trail, blue: lead};
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_channel(input string chan, input logic [LVL_W-1:0] want,
                                 input logic [LVL_W-1:0] got);
        if (want !== got)
            note_fail($sformatf("output %0d %s: expected %0d, got %0d",
                                out_count, chan, want, got));
    endtask

    // Sampled at the rising edge; inputs only move on the falling edge, so
    // reads here see settled values. Input accept queues an expected color,
    // output accept retires the oldest one. Also keeps the stall watchdog.
    always @(posedge clk) begin : monitor
        t_hsi seen;
        t_rgb want;
        t_rgb got;
        bit   moved;
        if (rst_n) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                moved      = 1'b1;
                seen.hue   = s_tdata[8:0];
                seen.sat   = s_tdata[19:9];
                seen.inten = s_tdata[30:20];
                rgb_due_q.push_back(cur_known ? cur_rgb : hsi_to_rgb_predict(seen));
            end
            if (m_tvalid && m_tready) begin
                moved     = 1'b1;
                got.red   = m_tdata[10:0];
                got.green = m_tdata[21:11];
                got.blue  = m_tdata[32:22];
                if (rgb_due_q.size() == 0) begin
                    note_fail($sformatf("output %0d: unexpected item r=%0d g=%0d b=%0d",
                                        out_count, got.red, got.green, got.blue));
                end else begin
                    want = rgb_due_q.pop_front();
                    check_channel("red",   want.red,   got.red);
                    check_channel("green", want.green, got.green);
                    check_channel("blue",  want.blue,  got.blue);
                end
                out_count++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: mostly short stalls, now and then a long one
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(9, 39);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        if (!tx_gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one item after an optional gap and hold it until accepted.
    task automatic send_color(input t_hsi item, input bit known, input t_rgb typed,
                              input int gap);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cur_known = known;
        cur_rgb   = typed;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, item.inten, item.sat, item.hue};   // bit 31 stays zero
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic t_hsi random_color();
        t_hsi item;
        int   kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            // whole field range, every bit toggles
            item.hue   = HUE_W'($urandom_range(0, 511));
            item.sat   = LVL_W'($urandom_range(0, 2047));
            item.inten = LVL_W'($urandom_range(0, 2047));
        end else if (kind < 8) begin
            // in-range colors, no saturation of the inputs
            item.hue   = HUE_W'($urandom_range(0, HUE_FULL_DEG - 1));
            item.sat   = LVL_W'($urandom_range(0, UNIT_LVL));
            item.inten = LVL_W'($urandom_range(0, UNIT_LVL));
        end else if (kind == 8) begin
            // sector edges, wrap and unit edges
            item.hue   = HUE_W'(HUE_EDGES[$urandom_range(0, 9)]);
            item.sat   = LVL_W'(LVL_EDGES[$urandom_range(0, 5)]);
            item.inten = LVL_W'(LVL_EDGES[$urandom_range(0, 5)]);
        end else begin
            // dim, barely saturated colors
            item.hue   = HUE_W'($urandom_range(0, 511));
            item.sat   = LVL_W'($urandom_range(0, 15));
            item.inten = LVL_W'($urandom_range(0, 15));
        end
        return item;
    endfunction

    initial begin : stimulus
        t_hsi item;
        t_rgb typed;
        int   mode;
        fill_hue_ratio();

        // reset held low at start, released on a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, with output stalls and an input gap before every fifth row
        rx_stalls_on = 1'b1;
        for (int n = 0; n < N_DIR; n++) begin
            item.hue    = HUE_W'(DIR_ROWS[n][COL_HUE]);
            item.sat    = LVL_W'(DIR_ROWS[n][COL_SAT]);
            item.inten  = LVL_W'(DIR_ROWS[n][COL_INT]);
            typed.red   = LVL_W'(DIR_ROWS[n][COL_RED]);
            typed.green = LVL_W'(DIR_ROWS[n][COL_GREEN]);
            typed.blue  = LVL_W'(DIR_ROWS[n][COL_BLUE]);
            send_color(item, DIR_ROWS[n][COL_KNOWN] != 0, typed, (n % 5 == 4) ? 2 : 0);
        end

        // random part; first span runs flat out, second idles on both sides
        for (int n = 0; n < N_RAND; n++) begin
            if (n % MODE_SPAN == 0) begin
                mode         = (n == 0) ? 0 : (n == MODE_SPAN) ? 3 : $urandom_range(0, 3);
                tx_gaps_on   = mode[0];
                rx_stalls_on = mode[1];
            end
            send_color(random_color(), 1'b0, '0, pick_gap());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain; the watchdog covers a result that never comes
        while (rgb_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rgb_due_q.size() != 0)
            note_fail($sformatf("%0d expected outputs never arrived", rgb_due_q.size()));

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: hsi_to_rgb_color_convert.f
rtl/core/hsi_cc_pkg.sv
rtl/core/hsi_cc_front.sv
rtl/core/hsi_cc_queue.sv
rtl/core/hsi_cc_back.sv
rtl/core/hsi_to_rgb_color_convert.sv
sim/testbench.sv
